// ----- hdl/rsl_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rsl_pkg: shared types and constants for the radial spotlight block
// Fixed-point constants of the falloff curve and the square-root stage type.
// ----------------------------------------------------------------------------
package rsl_pkg;

   // Centre registers are 14-bit signed; luminance is unsigned Q1.15.
   localparam int CENTER_BITS = 14;
   localparam int LUM_BITS    = 16;

   // Register indexes on the configuration port.
   localparam logic CSR_CENTER_X = 1'b0;
   localparam logic CSR_CENTER_Y = 1'b1;

   // Offsets of 160 pixels or more in either axis always saturate the curve.
   localparam int NEAR_LIMIT = 160;
   // 160 squared: squared distances at or above this saturate the curve.
   localparam int SQ_LIMIT   = 25600;
   localparam int SQ_BITS    = 15;

   // Falloff: k = FALL_DEN - dist8, held at FLOOR_K from distance 160 onwards.
   localparam logic [15:0] FALL_DEN = 16'd51200;
   localparam logic [15:0] FLOOR_K  = 16'd10240;

   // Division by 51200 = 2^11 * 25: shift, then reciprocal multiply by 1/25.
   localparam int          DIV_SHIFT   = 11;
   localparam int          QUOT_BITS   = 21;
   localparam int          RECIP_SHIFT = 26;
   localparam logic [21:0] RECIP_MUL   = 22'd2684354;
   localparam logic [5:0]  DIV_ODD     = 6'd25;

   // Square root: 16 result bits, four per pipeline stage.
   localparam int ROOT_BITS       = 16;
   localparam int RAD_BITS        = 2 * ROOT_BITS;
   localparam int REM_BITS        = ROOT_BITS + 2;
   localparam int STEPS_PER_STAGE = 4;
   localparam int SQRT_STAGES     = ROOT_BITS / STEPS_PER_STAGE;

   // Payload carried through one square-root stage.
   typedef struct packed {
      logic                  clamp;
      logic [LUM_BITS-1:0]   lum;
      logic [RAD_BITS-1:0]   rad;
      logic [REM_BITS-1:0]   rem;
      logic [ROOT_BITS-1:0]  root;
   } sqrt_data_type;

endpackage
`default_nettype wire

// ----- hdl/radial_spotlight_luma_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// radial_spotlight_luma_top: radial spotlight luminance falloff
// Scales each pixel's luminance by a factor that falls with its distance
// from a configurable centre.
// ----------------------------------------------------------------------------
// The block takes one pixel request per clock and returns one scaled
// luminance per request, in order. The pipeline has nine register stages
// (two for the offset and squared distance, four for the square root at four
// root bits a stage, three for the scaling and division by 51200) followed
// by an output register. The sustained rate is one pixel per clock; a
// stalled output is absorbed by a one-entry skid stage and then holds the
// whole pipeline. The centre registers should be written only while no
// request is in flight.
module radial_spotlight_luma_top
   import rsl_pkg::*;
#(
   parameter int COORD_BITS = 12
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // Request channel.
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   // tdata: pix_x, pix_y, lum_in from the lowest bit up, zero padded.
   input  wire logic [((2*COORD_BITS+LUM_BITS+7)/8)*8-1:0] req_tdata,
   // Result channel.
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   // tdata: lum_out.
   output logic [LUM_BITS-1:0]       rsp_tdata,
   // Configuration port.
   input  wire logic                 csr_psel,
   input  wire logic                 csr_penable,
   input  wire logic                 csr_pwrite,
   input  wire logic [2:0]           csr_paddr,
   input  wire logic [31:0]          csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);

   logic signed [CENTER_BITS-1:0] center_x_ff, center_y_ff;
   logic                          csr_write;
   logic                          enable;
   logic                          dist_valid;
   sqrt_data_type                 dist_data;
   logic                          sqrt_valid [SQRT_STAGES+1];
   sqrt_data_type                 sqrt_data  [SQRT_STAGES+1];
   logic                          scale_valid;
   logic [LUM_BITS-1:0]           scale_lum;

   // Centre registers.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
      end else if (csr_write) begin
         case (csr_paddr[2])
            CSR_CENTER_X: center_x_ff <= csr_pwdata[CENTER_BITS-1:0];
            CSR_CENTER_Y: center_y_ff <= csr_pwdata[CENTER_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Read data, sign extended.
   always_comb begin
      case (csr_paddr[2])
         CSR_CENTER_X: csr_prdata = 32'(center_x_ff);
         CSR_CENTER_Y: csr_prdata = 32'(center_y_ff);
         default:      csr_prdata = '0;
      endcase
   end

   assign req_tready = enable;

   rsl_dist #(
      .COORD_BITS(COORD_BITS)
   ) u_dist (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (req_tvalid),
      .pix_x     (req_tdata[COORD_BITS-1:0]),
      .pix_y     (req_tdata[2*COORD_BITS-1:COORD_BITS]),
      .lum_in    (req_tdata[2*COORD_BITS +: LUM_BITS]),
      .center_x  (center_x_ff),
      .center_y  (center_y_ff),
      .out_valid (dist_valid),
      .out_data  (dist_data)
   );

   // Square-root pipeline.
   assign sqrt_valid[0] = dist_valid;
   assign sqrt_data[0]  = dist_data;

   for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_sqrt
      rsl_sqrt_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .in_valid  (sqrt_valid[s]),
         .in_data   (sqrt_data[s]),
         .out_valid (sqrt_valid[s+1]),
         .out_data  (sqrt_data[s+1])
      );
   end

   rsl_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (sqrt_valid[SQRT_STAGES]),
      .in_data   (sqrt_data[SQRT_STAGES]),
      .out_valid (scale_valid),
      .lum_out   (scale_lum)
   );

   rsl_out_skid u_out (
      .clock      (clock),
      .reset      (reset),
      .enable     (enable),
      .push_valid (scale_valid),
      .push_data  (scale_lum),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_data   (rsp_tdata)
   );

endmodule
`default_nettype wire

// ----- hdl/rsl_dist.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rsl_dist: offset and squared distance
// Two stages: absolute offsets from the centre, then the squared distance
// with a saturation flag, formatted as the radicand of the square root.
// ----------------------------------------------------------------------------
module rsl_dist
   import rsl_pkg::*;
#(
   parameter int COORD_BITS = 12
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          enable,
   input  wire logic                          in_valid,
   input  wire logic [COORD_BITS-1:0]         pix_x,
   input  wire logic [COORD_BITS-1:0]         pix_y,
   input  wire logic [LUM_BITS-1:0]           lum_in,
   input  wire logic signed [CENTER_BITS-1:0] center_x,
   input  wire logic signed [CENTER_BITS-1:0] center_y,
   output logic                               out_valid,
   output sqrt_data_type                      out_data
);

   localparam int WIDE_BITS = (COORD_BITS + 1 > CENTER_BITS) ? COORD_BITS + 1 : CENTER_BITS;
   localparam int DIFF_BITS = WIDE_BITS + 1;

   logic signed [DIFF_BITS-1:0] dx, dy;
   logic [DIFF_BITS-1:0]        ax_in, ay_in, ax_ff, ay_ff;
   logic [LUM_BITS-1:0]         lum_ff;
   logic                        valid_a_ff, valid_b_ff;
   logic                        near;
   logic [16:0]                 sq;
   sqrt_data_type               data_b_in, data_b_ff;

   // Signed offsets and their magnitudes.
   always_comb begin
      dx    = $signed({{(DIFF_BITS-COORD_BITS){1'b0}}, pix_x})
              - DIFF_BITS'(center_x);
      dy    = $signed({{(DIFF_BITS-COORD_BITS){1'b0}}, pix_y})
              - DIFF_BITS'(center_y);
      ax_in = dx[DIFF_BITS-1] ? DIFF_BITS'(-dx) : DIFF_BITS'(dx);
      ay_in = dy[DIFF_BITS-1] ? DIFF_BITS'(-dy) : DIFF_BITS'(dy);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else if (enable) begin
         valid_a_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         ax_ff  <= ax_in;
         ay_ff  <= ay_in;
         lum_ff <= lum_in;
      end
   end

   // Squared distance on the low eight bits; larger offsets saturate anyway.
   always_comb begin
      near = (ax_ff < DIFF_BITS'(NEAR_LIMIT)) && (ay_ff < DIFF_BITS'(NEAR_LIMIT));
      sq   = 17'(ax_ff[7:0] * ax_ff[7:0]) + 17'(ay_ff[7:0] * ay_ff[7:0]);
      data_b_in.clamp = !near || (sq >= 17'(SQ_LIMIT));
      data_b_in.lum   = lum_ff;
      data_b_in.rad   = {1'b0, sq[SQ_BITS-1:0], {ROOT_BITS{1'b0}}};
      data_b_in.rem   = '0;
      data_b_in.root  = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_b_ff <= 1'b0;
      end else if (enable) begin
         valid_b_ff <= valid_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         data_b_ff <= data_b_in;
      end
   end

   assign out_valid = valid_b_ff;
   assign out_data  = data_b_ff;

endmodule
`default_nettype wire

// ----- hdl/rsl_sqrt_stage.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rsl_sqrt_stage: one stage of the pipelined integer square root
// Four restoring steps, each taking two radicand bits and giving one root bit.
// ----------------------------------------------------------------------------
module rsl_sqrt_stage
   import rsl_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          enable,
   input  wire logic          in_valid,
   input  wire sqrt_data_type in_data,
   output logic               out_valid,
   output sqrt_data_type      out_data
);

   sqrt_data_type data_in, data_ff;
   logic          valid_ff;

   // Restoring square-root steps on the remainder and partial root.
   always_comb begin
      logic [REM_BITS+1:0]  trial;
      logic [REM_BITS+1:0]  test;
      logic [REM_BITS-1:0]  rem_w;
      logic [ROOT_BITS-1:0] root_w;
      logic [RAD_BITS-1:0]  rad_w;
      rem_w  = in_data.rem;
      root_w = in_data.root;
      rad_w  = in_data.rad;
      for (int i = 0; i < STEPS_PER_STAGE; i++) begin
         trial = {rem_w, rad_w[RAD_BITS-1 -: 2]};
         test  = {2'b00, root_w, 2'b01};
         if (trial >= test) begin
            rem_w  = REM_BITS'(trial - test);
            root_w = {root_w[ROOT_BITS-2:0], 1'b1};
         end else begin
            rem_w  = trial[REM_BITS-1:0];
            root_w = {root_w[ROOT_BITS-2:0], 1'b0};
         end
         rad_w = {rad_w[RAD_BITS-3:0], 2'b00};
      end
      data_in       = in_data;
      data_in.rem   = rem_w;
      data_in.root  = root_w;
      data_in.rad   = rad_w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

// ----- hdl/rsl_scale.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rsl_scale: luminance scaling by the falloff factor
// Three stages: product with k, reciprocal multiply by 1/25 after a shift by
// 2^11, and a single correction step giving floor(lum * k / 51200).
// ----------------------------------------------------------------------------
module rsl_scale
   import rsl_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 enable,
   input  wire logic                 in_valid,
   input  wire sqrt_data_type        in_data,
   output logic                      out_valid,
   output logic [LUM_BITS-1:0]       lum_out
);

   logic [15:0]                    k;
   logic [31:0]                    prod_in, prod_ff;
   logic [QUOT_BITS-1:0]           t;
   logic [QUOT_BITS+21:0]          recip_prod;
   logic [QUOT_BITS-1:0]           t_ff;
   logic [QUOT_BITS-1:0]           q0_in, q0_ff;
   logic [QUOT_BITS-1:0]           rest;
   logic [QUOT_BITS-1:0]           q;
   logic [LUM_BITS-1:0]            lum_ff;
   logic                           valid_a_ff, valid_b_ff, valid_c_ff;

   // Falloff factor and product with the luminance.
   always_comb begin
      k       = in_data.clamp ? FLOOR_K : FALL_DEN - in_data.root;
      prod_in = in_data.lum * k;
   end

   // Approximate quotient by 25 from below, off by at most one.
   always_comb begin
      t          = prod_ff[DIV_SHIFT +: QUOT_BITS];
      recip_prod = t * RECIP_MUL;
      q0_in      = QUOT_BITS'(recip_prod >> RECIP_SHIFT);
   end

   // One correction step on the remainder.
   always_comb begin
      rest = t_ff - QUOT_BITS'(q0_ff * DIV_ODD);
      q    = (rest >= QUOT_BITS'(DIV_ODD)) ? q0_ff + 1'b1 : q0_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
         valid_c_ff <= 1'b0;
      end else if (enable) begin
         valid_a_ff <= in_valid;
         valid_b_ff <= valid_a_ff;
         valid_c_ff <= valid_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff <= prod_in;
         t_ff    <= t;
         q0_ff   <= q0_in;
         lum_ff  <= q[LUM_BITS-1:0];
      end
   end

   assign out_valid = valid_c_ff;
   assign lum_out   = lum_ff;

endmodule
`default_nettype wire

// ----- hdl/rsl_out_skid.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rsl_out_skid: output register with skid stage
// Holds the result for the downstream side and catches one extra result, so
// that the pipeline enable comes straight from a register.
// ----------------------------------------------------------------------------
module rsl_out_skid
   import rsl_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   output logic                      enable,
   input  wire logic                 push_valid,
   input  wire logic [LUM_BITS-1:0]  push_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [LUM_BITS-1:0]       rsp_data
);

   logic                main_valid_ff, main_valid_in;
   logic [LUM_BITS-1:0] main_data_ff, main_data_in;
   logic                skid_valid_ff, skid_valid_in;
   logic [LUM_BITS-1:0] skid_data_ff, skid_data_in;
   logic                main_free;

   assign enable = !skid_valid_ff;

   // The skid entry refills the output first; new results go to whichever
   // register is free.
   always_comb begin
      main_free     = !main_valid_ff || rsp_ready;
      main_valid_in = main_valid_ff;
      main_data_in  = main_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (main_free) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = push_valid;
            main_data_in  = push_data;
         end
      end else if (push_valid && enable) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_data_ff;

endmodule
`default_nettype wire

// ----- test/radial_spotlight_luma_top_tb.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// radial_spotlight_luma_top_tb: self-checking bench for the spotlight block
// Drives pixel requests with random gaps, back-pressures the result side,
// rewrites the centre registers between phases and checks each scaled
// luminance against a directed table value or an in-bench model of the radial falloff.
// ----------------------------------------------------------------------------
module radial_spotlight_luma_top_tb;
   import rsl_pkg::*;

   localparam int COORD_W       = 12;
   localparam int TDATA_W       = ((2*COORD_W+LUM_BITS+7)/8)*8;
   localparam int CYCLE_LIMIT   = 300000;
   localparam int DIRECTED_ROWS = 25;
   localparam int PHASES        = 7;
   localparam int PHASE_ITEMS   = 200;
   localparam int TAIL_CYCLES   = 30;

   typedef enum logic {ROW_CSR, ROW_PIXEL} row_kind_type;

   // One line of the directed stimulus table.
   typedef struct packed {
      row_kind_type             kind;
      logic                     csr_index;
      logic [CENTER_BITS-1:0]   csr_value;
      logic [COORD_W-1:0]       x;
      logic [COORD_W-1:0]       y;
      logic [LUM_BITS-1:0]      lum;
      logic                     fixed;
      logic [LUM_BITS-1:0]      lum_fixed;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // tdata: pix_x, pix_y, lum_in from the lowest bit up, zero padded.
   logic [TDATA_W-1:0]     req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // tdata: lum_out.
   logic [LUM_BITS-1:0]    rsp_tdata;
   logic                   csr_psel = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite = 1'b0;
   logic [2:0]             csr_paddr = '0;
   logic [31:0]            csr_pwdata = '0;
   logic [31:0]            csr_prdata;
   logic                   csr_pready;

   // Bench copy of the centre registers.
   logic signed [CENTER_BITS-1:0] centre_x = '0;
   logic signed [CENTER_BITS-1:0] centre_y = '0;

   logic [LUM_BITS-1:0]    lum_expected [$];
   logic [LUM_BITS-1:0]    lum_want;
   int unsigned            mismatches = 0;
   int unsigned            cycle_count = 0;
   int unsigned            rsp_hold = 0;
   int unsigned            rsp_pick;
   bit                     no_idle = 1'b0;
   stim_row_type           directed_rows [DIRECTED_ROWS];

   radial_spotlight_luma_top #(.COORD_BITS(COORD_W)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #10 clock = ~clock;

   // Expected luminance: distance from the centre by an exact square root with
   // eight fraction bits, multiplier k / 51200 held at the floor from 160 on.
   function automatic logic [LUM_BITS-1:0] spotlight_luma(input logic [COORD_W-1:0] x,
                                                          input logic [COORD_W-1:0] y,
                                                          input logic [LUM_BITS-1:0] lum);
      longint            off_x;
      longint            off_y;
      longint unsigned   radicand;
      longint unsigned   root;
      longint unsigned   trial;
      longint unsigned   gain;
      longint unsigned   scaled;
      off_x    = longint'(x) - longint'(centre_x);
      off_y    = longint'(y) - longint'(centre_y);
      radicand = longint'(off_x * off_x + off_y * off_y) << 16;
      root     = 0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= radicand) begin
            root = trial;
         end
      end
      if (root > longint'(FALL_DEN - FLOOR_K)) begin
         root = longint'(FALL_DEN - FLOOR_K);
      end
      gain   = longint'(FALL_DEN) - root;
      scaled = (longint'(lum) * gain) / longint'(FALL_DEN);
      return scaled[LUM_BITS-1:0];
   endfunction

   task automatic report_mismatch(input string what, input logic [LUM_BITS-1:0] got,
                                  input logic [LUM_BITS-1:0] want);
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got,
               want);
      mismatches++;
   endtask

   // Sends one pixel request after a random gap (none while no_idle is set) and records
   // its expectation at the edge where it is taken.
   task automatic send_pixel(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                             input logic [LUM_BITS-1:0] lum, input logic fixed,
                             input logic [LUM_BITS-1:0] lum_fixed);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= TDATA_W'({lum, y, x});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      lum_expected.push_back(fixed ? lum_fixed : spotlight_luma(x, y, lum));
   endtask

   // Writes one centre register once every request in flight has returned.
   task automatic csr_write(input logic index, input logic [CENTER_BITS-1:0] value);
      req_tvalid <= 1'b0;
      while (lum_expected.size() != 0) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= {{(32-CENTER_BITS){value[CENTER_BITS-1]}}, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (index == CSR_CENTER_X) begin
         centre_x = value;
      end else begin
         centre_y = value;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      // Idle bus cycle between transfers.
      @(posedge clock);
   endtask

   // Result side back-pressure: a random stall after each result taken.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold   <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         rsp_pick = no_idle ? 0 : $urandom_range(0, 5);
         rsp_hold   <= rsp_pick;
         rsp_tready <= (rsp_pick == 0);
      end else if (rsp_hold > 0) begin
         rsp_hold   <= rsp_hold - 1;
         rsp_tready <= (rsp_hold == 1);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Result checking against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (lum_expected.size() == 0) begin
            report_mismatch("result with no request waiting", rsp_tdata, '0);
         end else begin
            lum_want = lum_expected.pop_front();
            if (rsp_tdata !== lum_want) begin
               report_mismatch("lum_out", rsp_tdata, lum_want);
            end
         end
      end
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL radial_spotlight_luma_top");
         $finish;
      end
   end

   initial begin
      int px;
      int py;
      logic [LUM_BITS-1:0]    lum;
      logic [CENTER_BITS-1:0] cx;
      logic [CENTER_BITS-1:0] cy;

      // Directed table: after reset the centre is at the origin.
      directed_rows = '{
         '{ROW_PIXEL, CSR_CENTER_X, 14'd0, 12'd0, 12'd0, 16'd32768, 1'b1, 16'd32768},
         // Luminance above 1.0 passes unchanged at the centre.
         '{ROW_PIXEL, CSR_CENTER_X, 14'd0, 12'd0, 12'd0, 16'd65535, 1'b1, 16'd65535},
         '{ROW_PIXEL, CSR_CENTER_X, 14'd0, 12'd0, 12'd0, 16'd0, 1'b1, 16'd0},
         // Far corner: multiplier at the 0.2 floor.
         '{ROW_PIXEL, CSR_CENTER_X, 14'd0, 12'd4095, 12'd4095, 16'd32768, 1'b1, 16'd6553},
         '{ROW_PIXEL, CSR_CENTER_X, 14'd0, 12'd4095, 12'd4095, 16'd65535, 1'b1, 16'd13107},
         // Exactly at distance 160 the floor already applies.
         '{ROW_PIXEL, CSR_CENTER_X, 14'd0, 12'd160, 12'd0, 16'd51200, 1'b1, 16'd10240},
         '{ROW_PIXEL, CSR_CENTER_X, 14'd0, 12'd0, 12'd160, 16'd51200, 1'b1, 16'd10240},
         '{ROW_PIXEL, CSR_CENTER_X, 14'd0, 12'd100, 12'd0, 16'd51200, 1'b1, 16'd25600},
         '{ROW_PIXEL, CSR_CENTER_X, 14'd0, 12'd0, 12'd159, 16'd51200, 1'b1, 16'd10496},
         '{ROW_PIXEL, CSR_CENTER_X, 14'd0, 12'd3, 12'd4, 16'd51200, 1'b1, 16'd49920},
         '{ROW_PIXEL, CSR_CENTER_X, 14'd0, 12'd1, 12'd1, 16'd40000, 1'b0, 16'd0},
         // Centre at the positive extreme.
         '{ROW_CSR, CSR_CENTER_X, 14'd8191, 12'd0, 12'd0, 16'd0, 1'b0, 16'd0},
         '{ROW_CSR, CSR_CENTER_Y, 14'd8191, 12'd0, 12'd0, 16'd0, 1'b0, 16'd0},
         '{ROW_PIXEL, CSR_CENTER_X, 14'd0, 12'd4095, 12'd4095, 16'd65535, 1'b1, 16'd13107},
         '{ROW_PIXEL, CSR_CENTER_X, 14'd0, 12'd0, 12'd0, 16'd32768, 1'b1, 16'd6553},
         // Centre at the negative extreme (14'h2000 is -8192): largest offsets.
         '{ROW_CSR, CSR_CENTER_X, 14'h2000, 12'd0, 12'd0, 16'd0, 1'b0, 16'd0},
         '{ROW_CSR, CSR_CENTER_Y, 14'h2000, 12'd0, 12'd0, 16'd0, 1'b0, 16'd0},
         '{ROW_PIXEL, CSR_CENTER_X, 14'd0, 12'd4095, 12'd4095, 16'd65535, 1'b1, 16'd13107},
         '{ROW_PIXEL, CSR_CENTER_X, 14'd0, 12'd0, 12'd0, 16'd12345, 1'b1, 16'd2469},
         // Centre inside the image.
         '{ROW_CSR, CSR_CENTER_X, 14'd2048, 12'd0, 12'd0, 16'd0, 1'b0, 16'd0},
         '{ROW_CSR, CSR_CENTER_Y, 14'd2048, 12'd0, 12'd0, 16'd0, 1'b0, 16'd0},
         '{ROW_PIXEL, CSR_CENTER_X, 14'd0, 12'd2048, 12'd2048, 16'd65535, 1'b1, 16'd65535},
         '{ROW_PIXEL, CSR_CENTER_X, 14'd0, 12'd2049, 12'd2048, 16'd32768, 1'b0, 16'd0},
         '{ROW_PIXEL, CSR_CENTER_X, 14'd0, 12'd2047, 12'd2047, 16'd30000, 1'b0, 16'd0},
         '{ROW_PIXEL, CSR_CENTER_X, 14'd0, 12'd2148, 12'd2048, 16'd51200, 1'b1, 16'd25600}
      };

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            csr_write(directed_rows[i].csr_index, directed_rows[i].csr_value);
         end else begin
            send_pixel(directed_rows[i].x, directed_rows[i].y, directed_rows[i].lum,
                       directed_rows[i].fixed, directed_rows[i].lum_fixed);
         end
      end

      // Random phases, each with its own centre; some run without idling.
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin
               cx = 14'h3000;
               cy = 14'h3000;
            end
            1: begin
               cx = 14'd8191;
               cy = 14'h2000;
            end
            2, 5: begin
               cx = CENTER_BITS'($urandom);
               cy = CENTER_BITS'($urandom);
            end
            default: begin
               cx = CENTER_BITS'($urandom_range(0, 4095));
               cy = CENTER_BITS'($urandom_range(0, 4095));
            end
         endcase
         csr_write(CSR_CENTER_X, cx);
         csr_write(CSR_CENTER_Y, cy);
         no_idle = (phase % 3 == 1);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // Most pixels are aimed within 200 of the centre in each axis, around the sloped part of the curve.
            if ($urandom_range(0, 9) < 7) begin
               px = int'(centre_x) + int'($urandom_range(0, 400)) - 200;
               py = int'(centre_y) + int'($urandom_range(0, 400)) - 200;
            end else begin
               px = -1;
               py = -1;
            end
            if (px < 0 || px > 4095) begin
               px = $urandom_range(0, 4095);
            end
            if (py < 0 || py > 4095) begin
               py = $urandom_range(0, 4095);
            end
            case ($urandom_range(0, 7))
               0:       lum = '0;
               1:       lum = 16'd32768;
               2:       lum = 16'hFFFF;
               default: lum = LUM_BITS'($urandom);
            endcase
            send_pixel(COORD_W'(px), COORD_W'(py), lum, 1'b0, '0);
         end
      end

      // Drain, then let the pipeline settle.
      no_idle = 1'b0;
      req_tvalid <= 1'b0;
      while (lum_expected.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && lum_expected.size() == 0) begin
         $display("PASS radial_spotlight_luma_top");
      end else begin
         $display("FAIL radial_spotlight_luma_top");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ----- sim.f -----
hdl/rsl_pkg.sv
hdl/rsl_dist.sv
hdl/rsl_sqrt_stage.sv
hdl/rsl_scale.sv
hdl/rsl_out_skid.sv
hdl/radial_spotlight_luma_top.sv
test/radial_spotlight_luma_top_tb.sv
